### src/vltd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the varint length/type deframer.
// No dependencies; every other file of the block imports this package.
package vltd_pkg;

    // Result kinds carried on the result channel.
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_FAULT   = 2'd2;

    // Fault codes reported in a fault result.
    localparam logic [1:0] FAULT_INDICATOR = 2'd0;
    localparam logic [1:0] FAULT_LENGTH    = 2'd1;
    localparam logic [1:0] FAULT_TYPE      = 2'd2;
    localparam logic [1:0] FAULT_HEADER    = 2'd3;

    // Byte that opens every frame.
    localparam logic [7:0] INDICATOR_BYTE = 8'h00;

    // Reset value of the maximum payload length register.
    localparam logic [15:0] MAX_LEN_RESET = 16'hFFFF;

    // Depth of the queue between parser and output stage.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // One result record as produced by the parser.
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] length;
        logic [15:0] msg_type;
        logic [7:0]  data;
        logic        frame_end;
        logic [1:0]  fault;
    } vltd_rec_t;

endpackage

### src/vltd_front.sv
`timescale 1ns / 1ps
// Parser front end: accepts stream bytes, decodes the frame header varints,
// checks limits and pushes one result record per result. Uses vltd_pkg.
module vltd_front #(
    parameter int HEADER_BUF_BYTES = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [15:0]        cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    input  logic               q_full,
    output logic               push,
    output vltd_pkg::vltd_rec_t push_rec
);
    import vltd_pkg::*;

    localparam int CNT_W = $clog2(HEADER_BUF_BYTES + 1);

    // Parse phase codes.
    localparam logic [2:0] PH_IND  = 3'd0;
    localparam logic [2:0] PH_LEN  = 3'd1;
    localparam logic [2:0] PH_TYPE = 3'd2;
    localparam logic [2:0] PH_PAY  = 3'd3;
    localparam logic [2:0] PH_DEAD = 3'd4;

    logic [2:0]       phase_reg, phase_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [1:0]       group_reg, group_next;
    logic [15:0]      len_reg, len_next;
    logic [15:0]      typ_reg, typ_next;
    logic             big_reg, big_next;
    logic [15:0]      left_reg, left_next;
    logic [15:0]      max_len_reg;
    logic             accept;
    logic             emit;
    vltd_rec_t        rec;

    assign s_ready  = !q_full;
    assign accept   = s_valid && s_ready;
    assign push     = accept && emit;
    assign push_rec = rec;

    // Per-byte parser step.
    always_comb begin
        logic [CNT_W-1:0] cnt_inc;
        logic [15:0]      acc_cur;
        logic [15:0]      acc_new;
        logic             big_new;
        logic [6:0]       bits;
        logic [15:0]      left_dec;

        cnt_inc  = count_reg + CNT_W'(1);
        acc_cur  = (phase_reg == PH_LEN) ? len_reg : typ_reg;
        bits     = s_rx_byte[6:0];
        left_dec = left_reg - 16'd1;
        acc_new  = acc_cur;
        big_new  = big_reg;

        // Place the seven new bits by varint group; anything at bit 16 or
        // above marks the value as too large.
        case (group_reg)
            2'd0: acc_new = acc_cur | {9'd0, bits};
            2'd1: acc_new = acc_cur | {2'd0, bits, 7'd0};
            2'd2: begin
                acc_new = acc_cur | {bits[1:0], 14'd0};
                big_new = big_reg | (|bits[6:2]);
            end
            default: big_new = big_reg | (|bits);
        endcase

        phase_next = phase_reg;
        count_next = count_reg;
        group_next = group_reg;
        len_next   = len_reg;
        typ_next   = typ_reg;
        big_next   = big_reg;
        left_next  = left_reg;
        emit       = 1'b0;
        rec        = '0;

        case (phase_reg)
            PH_IND: begin
                if (s_rx_byte != INDICATOR_BYTE) begin
                    phase_next = PH_DEAD;
                    emit       = 1'b1;
                    rec.kind   = KIND_FAULT;
                    rec.fault  = FAULT_INDICATOR;
                end else begin
                    count_next = CNT_W'(1);
                    group_next = 2'd0;
                    len_next   = 16'd0;
                    typ_next   = 16'd0;
                    big_next   = 1'b0;
                    phase_next = PH_LEN;
                end
            end
            PH_LEN, PH_TYPE: begin
                count_next = cnt_inc;
                if (cnt_inc >= CNT_W'(HEADER_BUF_BYTES)) begin
                    phase_next = PH_DEAD;
                    emit       = 1'b1;
                    rec.kind   = KIND_FAULT;
                    rec.fault  = FAULT_HEADER;
                end else begin
                    big_next   = big_new;
                    group_next = (group_reg == 2'd3) ? 2'd3 : group_reg + 2'd1;
                    if (phase_reg == PH_LEN) begin
                        len_next = acc_new;
                        if (!s_rx_byte[7]) begin
                            if (big_new || (acc_new > max_len_reg)) begin
                                phase_next = PH_DEAD;
                                emit       = 1'b1;
                                rec.kind   = KIND_FAULT;
                                rec.fault  = FAULT_LENGTH;
                            end else begin
                                group_next = 2'd0;
                                phase_next = PH_TYPE;
                            end
                        end
                    end else begin
                        typ_next = acc_new;
                        if (!s_rx_byte[7]) begin
                            emit = 1'b1;
                            if (big_new) begin
                                phase_next = PH_DEAD;
                                rec.kind   = KIND_FAULT;
                                rec.fault  = FAULT_TYPE;
                            end else begin
                                group_next    = 2'd0;
                                count_next    = '0;
                                left_next     = len_reg;
                                rec.kind      = KIND_HEADER;
                                rec.length    = len_reg;
                                rec.msg_type  = acc_new;
                                rec.frame_end = (len_reg == 16'd0);
                                phase_next    = (len_reg == 16'd0) ? PH_IND : PH_PAY;
                            end
                        end
                    end
                end
            end
            PH_PAY: begin
                left_next     = left_dec;
                emit          = 1'b1;
                rec.kind      = KIND_PAYLOAD;
                rec.length    = len_reg;
                rec.msg_type  = typ_reg;
                rec.data      = s_rx_byte;
                rec.frame_end = (left_dec == 16'd0);
                if (left_dec == 16'd0) begin
                    phase_next = PH_IND;
                end
            end
            default: begin
                // After a fault every byte is dropped until reset.
                emit = 1'b0;
            end
        endcase
    end

    // Parser state and the configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IND;
            count_reg   <= '0;
            group_reg   <= 2'd0;
            len_reg     <= 16'd0;
            typ_reg     <= 16'd0;
            big_reg     <= 1'b0;
            left_reg    <= 16'd0;
            max_len_reg <= MAX_LEN_RESET;
        end else begin
            if (cfg_wr_en) begin
                max_len_reg <= cfg_wr_data;
            end
            if (accept) begin
                phase_reg <= phase_next;
                count_reg <= count_next;
                group_reg <= group_next;
                len_reg   <= len_next;
                typ_reg   <= typ_next;
                big_reg   <= big_next;
                left_reg  <= left_next;
            end
        end
    end

    // A fault result always leaves the parser locked.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && push_rec.kind == KIND_FAULT) |=> (phase_reg == PH_DEAD))
        else $error("fault result did not lock the parser");

    // Once locked, nothing more is pushed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_DEAD) |-> !push)
        else $error("result pushed after a fault");

    // While payload bytes are pending the remaining count is never zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_PAY) |-> (left_reg != 16'd0))
        else $error("payload phase with no bytes left");

    // The header count stays below the buffer size while decoding varints.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_LEN || phase_reg == PH_TYPE)
            |-> (count_reg < CNT_W'(HEADER_BUF_BYTES)))
        else $error("header count reached the buffer size");

endmodule

### src/vltd_queue.sv
`timescale 1ns / 1ps
// Small register queue of result records between parser and output stage.
// Uses vltd_pkg for the record type and depth.
module vltd_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  vltd_pkg::vltd_rec_t push_rec,
    output logic                full,
    input  logic                pop,
    output vltd_pkg::vltd_rec_t pop_rec,
    output logic                empty
);
    import vltd_pkg::*;

    vltd_rec_t              slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;

    assign full    = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_rec = slot_reg[rd_ptr_reg];

    // Record storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_rec;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + QUEUE_CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - QUEUE_CNT_W'(1);
            end
        end
    end

endmodule

### src/vltd_back.sv
`timescale 1ns / 1ps
// Output stage: takes records from the queue, formats the fields for the
// result kind and holds them in the output register. Uses vltd_pkg.
module vltd_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_empty,
    input  vltd_pkg::vltd_rec_t q_rec,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_result_kind,
    output logic [15:0]         m_payload_length,
    output logic [15:0]         m_message_kind,
    output logic [7:0]          m_payload_byte,
    output logic                m_frame_end,
    output logic [1:0]          m_fault_code
);
    import vltd_pkg::*;

    logic      valid_reg;
    vltd_rec_t out_reg;
    vltd_rec_t fmt;

    // Load a new record when the register is empty or being drained.
    assign pop = !q_empty && (!valid_reg || m_ready);

    // Clear the fields that do not belong to the record's kind.
    always_comb begin
        fmt = q_rec;
        if (q_rec.kind == KIND_FAULT) begin
            fmt.length    = 16'd0;
            fmt.msg_type  = 16'd0;
            fmt.frame_end = 1'b0;
        end else begin
            fmt.fault = 2'd0;
        end
        if (q_rec.kind != KIND_PAYLOAD) begin
            fmt.data = 8'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_reg <= fmt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pop) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    assign m_valid          = valid_reg;
    assign m_result_kind    = out_reg.kind;
    assign m_payload_length = out_reg.length;
    assign m_message_kind   = out_reg.msg_type;
    assign m_payload_byte   = out_reg.data;
    assign m_frame_end      = out_reg.frame_end;
    assign m_fault_code     = out_reg.fault;

endmodule

### src/varint_length_type_deframer.sv
`timescale 1ns / 1ps
// Top level of the varint length/type deframer.
// Instantiates vltd_front, vltd_queue and vltd_back; uses vltd_pkg.
//
// The block takes one stream byte per cycle, back to back, and each byte
// yields at most one result. A parser front end decodes the indicator, the
// length and type varints and the payload with one step of per-byte logic,
// and writes results into a four-entry queue; an output register takes them
// from there, so each result is registered in the queue and then in the
// output register before it is presented on the m_ channel. Input is
// stalled only when the queue is full, which happens only while m_ready is
// held low. After any fault result the block drops all input until reset.
// There is no start-up pass after reset.
module varint_length_type_deframer #(
    parameter int HEADER_BUF_BYTES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_result_kind,
    output logic [15:0] m_payload_length,
    output logic [15:0] m_message_kind,
    output logic [7:0]  m_payload_byte,
    output logic        m_frame_end,
    output logic [1:0]  m_fault_code
);
    import vltd_pkg::*;

    logic      push;
    logic      pop;
    logic      q_full;
    logic      q_empty;
    vltd_rec_t push_rec;
    vltd_rec_t pop_rec;

    // Parser front end.
    vltd_front #(
        .HEADER_BUF_BYTES(HEADER_BUF_BYTES)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_rx_byte   (s_rx_byte),
        .q_full      (q_full),
        .push        (push),
        .push_rec    (push_rec)
    );

    // Result queue.
    vltd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_rec (push_rec),
        .full     (q_full),
        .pop      (pop),
        .pop_rec  (pop_rec),
        .empty    (q_empty)
    );

    // Output stage.
    vltd_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_empty          (q_empty),
        .q_rec            (pop_rec),
        .pop              (pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_kind    (m_result_kind),
        .m_payload_length (m_payload_length),
        .m_message_kind   (m_message_kind),
        .m_payload_byte   (m_payload_byte),
        .m_frame_end      (m_frame_end),
        .m_fault_code     (m_fault_code)
    );

endmodule

### tb/vltd_frame_checker.sv
`timescale 1ns / 1ps
// Checker for varint_length_type_deframer: watches the s_, m_ and configuration ports,
// predicts every result from the accepted bytes and compares it. Depends on vltd_pkg.
module vltd_frame_checker #(
    parameter int HEADER_BUF_BYTES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_result_kind,
    input  logic [15:0] m_payload_length,
    input  logic [15:0] m_message_kind,
    input  logic [7:0]  m_payload_byte,
    input  logic        m_frame_end,
    input  logic [1:0]  m_fault_code,
    output int          mismatch_count,
    output int          pending_results
);
    import vltd_pkg::*;

    typedef enum logic [2:0] {
        PH_INDICATOR,
        PH_LENGTH,
        PH_TYPE,
        PH_PAYLOAD,
        PH_HALTED
    } parse_phase_t;

    // Shadow copy of the parser state and of the length limit register.
    parse_phase_t phase;
    int           hdr_count;
    logic [5:0]   group_shift;
    logic [31:0]  length_acc;
    logic [31:0]  type_acc;
    logic [15:0]  bytes_left;
    logic [15:0]  max_length;

    vltd_rec_t    predicted_records[$];
    int           miscompare_total = 0;

    // Merge one base-128 group into an accumulator; anything that lands at
    // bit 32 or above saturates the accumulator.
    function automatic logic [31:0] merge_group(logic [31:0] acc, logic [7:0] b,
                                                logic [5:0] shift);
        logic [63:0] wide;
        if (b[6:0] == 7'd0)
            return acc;
        if (shift >= 6'd32)
            return 32'hFFFF_FFFF;
        wide = {57'd0, b[6:0]} << shift;
        if (wide[63:32] != 32'd0)
            return 32'hFFFF_FFFF;
        return acc | wide[31:0];
    endfunction

    function automatic logic [5:0] advance_shift(logic [5:0] shift);
        return (shift + 6'd7 > 6'd35) ? 6'd35 : shift + 6'd7;
    endfunction

    function automatic string record_text(vltd_rec_t r);
        return $sformatf("kind=%0d length=%0d type=%0d data=%02h end=%0b fault=%0d",
                         r.kind, r.length, r.msg_type, r.data, r.frame_end, r.fault);
    endfunction

    task automatic raise_fault(input logic [1:0] code);
        vltd_rec_t rec;
        rec = '0;
        rec.kind  = KIND_FAULT;
        rec.fault = code;
        phase = PH_HALTED;
        predicted_records.push_back(rec);
    endtask

    // Advance the shadow parser by one accepted byte and queue its result, if any.
    task automatic decode_stream_byte(input logic [7:0] b);
        vltd_rec_t rec;
        rec = '0;
        case (phase)
            PH_INDICATOR: begin
                if (b != INDICATOR_BYTE) begin
                    raise_fault(FAULT_INDICATOR);
                end else begin
                    hdr_count   = 1;
                    group_shift = 6'd0;
                    length_acc  = 32'd0;
                    type_acc    = 32'd0;
                    phase       = PH_LENGTH;
                end
            end
            PH_LENGTH, PH_TYPE: begin
                // The buffer limit wins over a varint that would complete here.
                hdr_count++;
                if (hdr_count >= HEADER_BUF_BYTES) begin
                    raise_fault(FAULT_HEADER);
                end else if (phase == PH_LENGTH) begin
                    length_acc  = merge_group(length_acc, b, group_shift);
                    group_shift = advance_shift(group_shift);
                    if (!b[7]) begin
                        if (length_acc > {16'd0, max_length}) begin
                            raise_fault(FAULT_LENGTH);
                        end else begin
                            group_shift = 6'd0;
                            phase       = PH_TYPE;
                        end
                    end
                end else begin
                    type_acc    = merge_group(type_acc, b, group_shift);
                    group_shift = advance_shift(group_shift);
                    if (!b[7]) begin
                        if (type_acc > 32'h0000_FFFF) begin
                            raise_fault(FAULT_TYPE);
                        end else begin
                            group_shift  = 6'd0;
                            hdr_count    = 0;
                            bytes_left   = length_acc[15:0];
                            rec.kind     = KIND_HEADER;
                            rec.msg_type = type_acc[15:0];
                            if (bytes_left == 16'd0) begin
                                rec.frame_end = 1'b1;
                                phase         = PH_INDICATOR;
                            end else begin
                                rec.length = length_acc[15:0];
                                phase      = PH_PAYLOAD;
                            end
                            predicted_records.push_back(rec);
                        end
                    end
                end
            end
            PH_PAYLOAD: begin
                bytes_left   = bytes_left - 16'd1;
                rec.kind     = KIND_PAYLOAD;
                rec.length   = length_acc[15:0];
                rec.msg_type = type_acc[15:0];
                rec.data     = b;
                if (bytes_left == 16'd0) begin
                    rec.frame_end = 1'b1;
                    phase         = PH_INDICATOR;
                end
                predicted_records.push_back(rec);
            end
            default: begin
                // After a fault every byte is dropped.
            end
        endcase
    endtask

    // Sample both channels at the rising edge: predict first, then compare.
    always @(posedge aclk) begin
        vltd_rec_t seen;
        vltd_rec_t want;
        if (!aresetn) begin
            phase       = PH_INDICATOR;
            hdr_count   = 0;
            group_shift = 6'd0;
            length_acc  = 32'd0;
            type_acc    = 32'd0;
            bytes_left  = 16'd0;
            max_length  = MAX_LEN_RESET;
            predicted_records.delete();
        end else begin
            if (cfg_wr_en)
                max_length = cfg_wr_data;
            if (s_valid && s_ready)
                decode_stream_byte(s_rx_byte);
            if (m_valid && m_ready) begin
                seen.kind      = m_result_kind;
                seen.length    = m_payload_length;
                seen.msg_type  = m_message_kind;
                seen.data      = m_payload_byte;
                seen.frame_end = m_frame_end;
                seen.fault     = m_fault_code;
                if (predicted_records.size() == 0) begin
                    miscompare_total++;
                    if (miscompare_total <= 10)
                        $display("%0t: unexpected result: %s", $realtime, record_text(seen));
                end else begin
                    want = predicted_records.pop_front();
                    if (seen.kind !== want.kind || seen.length !== want.length
                            || seen.msg_type !== want.msg_type || seen.data !== want.data
                            || seen.frame_end !== want.frame_end
                            || seen.fault !== want.fault) begin
                        miscompare_total++;
                        if (miscompare_total <= 10)
                            $display("%0t: result mismatch: expected %s, actual %s",
                                     $realtime, record_text(want), record_text(seen));
                    end
                end
            end
        end
        pending_results = predicted_records.size();
        mismatch_count  = miscompare_total;
    end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Top of the deframer testbench: clock, reset, byte stream stimulus and verdict.
// Depends on vltd_pkg, varint_length_type_deframer and vltd_frame_checker.
module testbench;
    import vltd_pkg::*;

    localparam int HDR_BUF_BYTES = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_BYTES   = 70;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = 16'd0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte   = 8'd0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [1:0]  m_result_kind;
    logic [15:0] m_payload_length;
    logic [15:0] m_message_kind;
    logic [7:0]  m_payload_byte;
    logic        m_frame_end;
    logic [1:0]  m_fault_code;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int cycle_count    = 0;
    int mismatch_count;
    int pending_results;

    always #5 aclk = ~aclk;

    varint_length_type_deframer #(
        .HEADER_BUF_BYTES(HDR_BUF_BYTES)
    ) u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_kind   (m_result_kind),
        .m_payload_length(m_payload_length),
        .m_message_kind  (m_message_kind),
        .m_payload_byte  (m_payload_byte),
        .m_frame_end     (m_frame_end),
        .m_fault_code    (m_fault_code)
    );

    vltd_frame_checker #(
        .HEADER_BUF_BYTES(HDR_BUF_BYTES)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_kind   (m_result_kind),
        .m_payload_length(m_payload_length),
        .m_message_kind  (m_message_kind),
        .m_payload_byte  (m_payload_byte),
        .m_frame_end     (m_frame_end),
        .m_fault_code    (m_fault_code),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    // The receiver stalls at random according to the current idling mode.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99, 0) >= sink_stall_pct);
    end

    // Watchdog: a hung run ends here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Idling modes: none, sender idle, receiver stalling, both lightly.
    task automatic set_idling(input int mode);
        case (mode)
            1: begin
                src_idle_pct   = 68;
                sink_stall_pct = 0;
            end
            2: begin
                src_idle_pct   = 0;
                sink_stall_pct = 68;
            end
            3: begin
                src_idle_pct   = 7;
                sink_stall_pct = 7;
            end
            default: begin
                src_idle_pct   = 0;
                sink_stall_pct = 0;
            end
        endcase
    endtask

    // Offer one byte and hold it until the transaction completes.
    // Called and returns at a falling edge.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99, 0) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do
            @(posedge aclk);
        while (!s_ready);
        @(negedge aclk);
    endtask

    // Sender pause: wait until every expected result has come, and let a byte
    // that may still be inside the block come out.
    task automatic drain_pipeline();
        s_valid <= 1'b0;
        while (pending_results != 0)
            @(negedge aclk);
        repeat (6) @(negedge aclk);
    endtask

    task automatic write_max_length(input logic [15:0] limit);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= limit;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic int min_groups(logic [31:0] v);
        int n;
        n = 1;
        while (n < 5 && (v >> (7 * n)) != 32'd0)
            n++;
        return n;
    endfunction

    // Little-endian base-128 encoding; more groups than needed pad with zeros.
    task automatic send_varint(input logic [31:0] v, input int groups);
        logic [7:0] b;
        for (int i = 0; i < groups; i++) begin
            b[6:0] = 7'(v >> (7 * i));
            b[7]   = (i < groups - 1);
            send_byte(b);
        end
    endtask

    task automatic send_header(input logic [15:0] len, input logic [15:0] kind,
                               input int len_groups, input int kind_groups);
        send_byte(INDICATOR_BYTE);
        send_varint({16'd0, len}, len_groups);
        send_varint({16'd0, kind}, kind_groups);
    endtask

    // One well-formed frame with random content that fits the current limit.
    task automatic send_random_frame(input logic [15:0] max_len, inout int budget);
        int          r;
        int          len;
        int          lg;
        int          tg;
        int          room;
        logic [15:0] kind;
        r = $urandom_range(99, 0);
        if (max_len == 16'd0 || r < 15)
            len = 0;
        else if (r < 85)
            len = $urandom_range((max_len < 12) ? max_len : 12, 1);
        else if (max_len <= 16'd300)
            len = max_len;
        else
            len = $urandom_range(300, 1);
        r = $urandom_range(9, 0);
        if (r < 2)
            kind = 16'd0;
        else if (r < 4)
            kind = 16'hFFFF;
        else if (r < 7)
            kind = $urandom_range(127, 0);
        else
            kind = $urandom_range(65535, 0);
        // Non-minimal varints, as long as the header still fits its buffer.
        lg   = min_groups(len);
        tg   = min_groups({16'd0, kind});
        room = 6 - lg - tg;
        if (room > 0 && $urandom_range(3, 0) == 0)
            lg += $urandom_range(room, 1);
        room = 6 - lg - tg;
        if (room > 0 && $urandom_range(3, 0) == 0)
            tg += $urandom_range(room, 1);
        send_header(len, kind, lg, tg);
        repeat (len) send_byte($urandom_range(255, 0));
        budget -= 1 + lg + tg + len;
    endtask

    // A fault stops the block until reset, so the run ends with exactly one,
    // picked at random, followed by a few bytes that must be dropped.
    task automatic send_fault_sequence();
        logic [1:0]  pick;
        logic [15:0] limit;
        logic [31:0] v;
        int          n;
        pick = $urandom_range(3, 0);
        case (pick)
            FAULT_INDICATOR: begin
                send_byte($urandom_range(255, 1));
            end
            FAULT_LENGTH: begin
                if ($urandom_range(1, 0) == 0) begin
                    limit = $urandom_range(1000, 0);
                    write_max_length(limit);
                    v = limit + 1 + $urandom_range(50, 0);
                    send_byte(INDICATOR_BYTE);
                    send_varint(v, min_groups(v));
                end else begin
                    // Five groups reach bit 28 and up, often saturating.
                    send_byte(INDICATOR_BYTE);
                    repeat (4) send_byte(8'h80 | $urandom_range(127, 0));
                    send_byte($urandom_range(127, 1));
                end
            end
            FAULT_TYPE: begin
                send_byte(INDICATOR_BYTE);
                send_byte(8'h00);
                n = $urandom_range(5, 3);
                repeat (n - 1) send_byte(8'h80 | $urandom_range(127, 0));
                send_byte((n == 3) ? $urandom_range(127, 4) : $urandom_range(127, 1));
            end
            default: begin
                // Header overflow: the eighth header byte trips the limit,
                // whatever its continuation bit says.
                send_byte(INDICATOR_BYTE);
                if ($urandom_range(1, 0) == 0) begin
                    send_byte(8'h00);
                    repeat (5) send_byte(8'h80 | $urandom_range(127, 0));
                end else begin
                    repeat (6) send_byte(8'h80 | $urandom_range(127, 0));
                end
                send_byte($urandom_range(255, 0));
            end
        endcase
        repeat ($urandom_range(6, 1)) send_byte($urandom_range(255, 0));
    endtask

    initial begin
        logic [15:0] max_len;
        int          budget;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed frames under the reset limit: empty frame, largest type,
        // longest legal header, padded type and extreme payload bytes.
        set_idling(0);
        send_header(16'd0, 16'd0, 1, 1);
        send_header(16'd1, 16'hFFFF, 1, 3);
        send_byte(8'hAA);
        send_header(16'd0, 16'd0, 5, 1);
        send_header(16'd2, 16'd1, 1, 2);
        send_byte(8'h00);
        send_byte(8'hFF);

        // One frame with a two-group length padded to three groups, without idling.
        drain_pipeline();
        write_max_length(16'hFFFF);
        send_header(16'd130, 16'd0, 3, 1);
        repeat (130) send_byte($urandom_range(255, 0));

        // Random phases, each under its own limit and idling mode.
        for (int p = 0; p < 8; p++) begin
            drain_pipeline();
            case (p)
                0:       max_len = 16'hFFFF;
                1:       max_len = 16'd0;
                2:       max_len = 16'd1;
                3:       max_len = $urandom_range(20, 2);
                4:       max_len = $urandom_range(65535, 0);
                5:       max_len = 16'hFFFF;
                6:       max_len = 16'd255;
                default: max_len = $urandom_range(3000, 300);
            endcase
            write_max_length(max_len);
            set_idling(p % 4);
            budget = PHASE_BYTES;
            while (budget > 0)
                send_random_frame(max_len, budget);
        end

        drain_pipeline();
        set_idling(3);
        send_fault_sequence();
        drain_pipeline();

        if (mismatch_count == 0 && pending_results == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
